// File: design/hsst_pkg.sv
package hsst_pkg;

	// default sizing for the top level
	localparam int TABLE_SIZE_DEF   = 499;
	localparam int MAX_NAME_LEN_DEF = 255;
	localparam int HANDLE_WIDTH_DEF = 16;

	// fixed hash constants
	localparam int CHAR_W     = 7;
	localparam int POS_OFFSET = 222;
	localparam int HASH_SHIFT = 4;

	// request operation
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// finished name from the hash unit to the table
	typedef struct packed {
		logic valid;
		logic lookup;
	} name_ctl_t;

	// table status back to the hash unit
	typedef struct packed {
		logic take;
		logic clearing;
	} table_stat_t;

endpackage

// File: design/hsst_if.sv
// character request channel
interface hsst_chars_if #(
	parameter int HANDLE_WIDTH = hsst_pkg::HANDLE_WIDTH_DEF
) ();
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [hsst_pkg::CHAR_W-1:0] char_code;
	logic                        is_last;
	logic [HANDLE_WIDTH-1:0]     symbol_handle;

	modport source (output valid, operation, char_code, is_last, symbol_handle, input ready);
	modport sink   (input valid, operation, char_code, is_last, symbol_handle, output ready);
endinterface

// result channel
interface hsst_results_if #(
	parameter int HANDLE_WIDTH = hsst_pkg::HANDLE_WIDTH_DEF,
	parameter int IDX_W        = $clog2(hsst_pkg::TABLE_SIZE_DEF)
) ();
	logic                    valid;
	logic                    ready;
	logic                    success;
	logic [HANDLE_WIDTH-1:0] found_handle;
	logic [IDX_W-1:0]        slot_index;

	modport source (output valid, success, found_handle, slot_index, input ready);
	modport sink   (input valid, success, found_handle, slot_index, output ready);
endinterface

// File: design/hsst_hash.sv
// Running name hash: product, reciprocal reduction, then the hash register.
module hsst_hash #(
	parameter int TABLE_SIZE   = hsst_pkg::TABLE_SIZE_DEF,
	parameter int MAX_NAME_LEN = hsst_pkg::MAX_NAME_LEN_DEF,
	parameter int HANDLE_WIDTH = hsst_pkg::HANDLE_WIDTH_DEF,
	parameter int IDX_W        = $clog2(TABLE_SIZE)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hsst_chars_if.sink            chars,
	input  hsst_pkg::table_stat_t stat,
	output hsst_pkg::name_ctl_t   ctl,
	output logic [IDX_W-1:0]      idx,
	output logic [HANDLE_WIDTH-1:0] handle
);

	localparam int PW = $clog2(MAX_NAME_LEN + 1);
	localparam int XW = hsst_pkg::CHAR_W + IDX_W;
	// exact reciprocal for x < 2**XW
	localparam int SH = XW + IDX_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam int MW = XW + 2;
	localparam int RW = XW + MW;
	localparam logic [MW-1:0]    RECIP  = MW'(RECIP_L);
	localparam logic [XW-1:0]    T_X    = XW'(TABLE_SIZE);
	localparam logic [IDX_W:0]   T_H    = (IDX_W + 1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] K0     = IDX_W'(hsst_pkg::POS_OFFSET % TABLE_SIZE);
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'(TABLE_SIZE - 1);
	localparam logic [PW-1:0]    POS_MAX = PW'(MAX_NAME_LEN);

	logic                  accept;
	logic                  en1, en2, en3, en4, adv4;
	logic [PW-1:0]         pos_q;
	logic [IDX_W-1:0]      k_q;
	logic [IDX_W-1:0]      h_q;
	logic [IDX_W-1:0]      h_new;
	logic [IDX_W:0]        acc;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic                  last_s1, last_s2, last_s3, last_s4;
	logic                  lookup_s1, lookup_s2, lookup_s3, lookup_s4;
	logic [HANDLE_WIDTH-1:0] handle_s1, handle_s2, handle_s3, handle_s4;
	logic [hsst_pkg::CHAR_W-1:0] c_s1;
	logic [IDX_W-1:0]      k_s1;
	logic [XW-1:0]         x_s2, x_s3;
	logic [XW-1:0]         q_s3;
	logic [IDX_W-1:0]      p_s4;

	// stage enables: a stage loads when empty or when it drains
	assign adv4 = v_s4 && (!last_s4 || stat.take);
	assign en4  = !v_s4 || adv4;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;

	assign chars.ready = en1 && !stat.clearing;
	assign accept      = chars.valid && chars.ready;

	// position and (position + offset) mod size, both saturating together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			k_q   <= K0;
		end else if (accept) begin
			if (chars.is_last) begin
				pos_q <= '0;
				k_q   <= K0;
			end else if (pos_q < POS_MAX) begin
				pos_q <= pos_q + PW'(1);
				k_q   <= (k_q == K_LAST) ? '0 : k_q + IDX_W'(1);
			end
		end
	end

	// valid bits and hash register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			h_q  <= '0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (adv4) h_q <= last_s4 ? '0 : h_new;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en1) begin
			c_s1      <= chars.char_code;
			k_s1      <= k_q;
			last_s1   <= chars.is_last;
			lookup_s1 <= (chars.operation == hsst_pkg::OP_LOOKUP);
			handle_s1 <= chars.symbol_handle;
		end
		// character times position weight
		if (en2) begin
			x_s2      <= XW'(c_s1) * XW'(k_s1);
			last_s2   <= last_s1;
			lookup_s2 <= lookup_s1;
			handle_s2 <= handle_s1;
		end
		// quotient by reciprocal
		if (en3) begin
			q_s3      <= XW'((RW'(x_s2) * RW'(RECIP)) >> SH);
			x_s3      <= x_s2;
			last_s3   <= last_s2;
			lookup_s3 <= lookup_s2;
			handle_s3 <= handle_s2;
		end
		// remainder
		if (en4) begin
			p_s4      <= IDX_W'(x_s3 - q_s3 * T_X);
			last_s4   <= last_s3;
			lookup_s4 <= lookup_s3;
			handle_s4 <= handle_s3;
		end
	end

	// (h << 4 + p) mod size by modular doublings and one modular add
	always_comb begin
		acc = {1'b0, h_q};
		for (int i = 0; i < hsst_pkg::HASH_SHIFT; i++) begin
			acc = {acc[IDX_W-1:0], 1'b0};
			if (acc >= T_H) acc = acc - T_H;
		end
		acc = acc + {1'b0, p_s4};
		if (acc >= T_H) acc = acc - T_H;
		h_new = acc[IDX_W-1:0];
	end

	// finished name toward the table
	assign ctl.valid  = v_s4 && last_s4;
	assign ctl.lookup = lookup_s4;
	assign idx        = h_new;
	assign handle     = handle_s4;

endmodule

// File: design/hsst_table.sv
// Slot memory with read stage, insert/lookup decision and result register.
module hsst_table #(
	parameter int TABLE_SIZE   = hsst_pkg::TABLE_SIZE_DEF,
	parameter int HANDLE_WIDTH = hsst_pkg::HANDLE_WIDTH_DEF,
	parameter int IDX_W        = $clog2(TABLE_SIZE)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hsst_pkg::name_ctl_t     ctl,
	input  logic [IDX_W-1:0]        idx,
	input  logic [HANDLE_WIDTH-1:0] handle,
	output hsst_pkg::table_stat_t   stat,
	hsst_results_if.source          results
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

	logic [HANDLE_WIDTH-1:0] mem [TABLE_SIZE];

	logic                    clr_q;
	logic [IDX_W-1:0]        clr_idx_q;
	logic                    take, en_out, wr_en;
	logic                    slot_empty, ins_ok;

	logic                    v_s5;
	logic                    lookup_s5;
	logic [IDX_W-1:0]        idx_s5;
	logic [HANDLE_WIDTH-1:0] handle_s5;
	logic [HANDLE_WIDTH-1:0] rd_s5;

	logic                    out_v_q;
	logic                    succ_q;
	logic [HANDLE_WIDTH-1:0] found_q;
	logic [IDX_W-1:0]        idx_q;

	assign en_out = !out_v_q || results.ready;
	assign take   = !v_s5 || en_out;

	assign stat.take     = take;
	assign stat.clearing = clr_q;

	// decision on the slot just read
	assign slot_empty = (rd_s5 == '0);
	assign ins_ok     = !lookup_s5 && slot_empty && (handle_s5 != '0);
	assign wr_en      = v_s5 && en_out && ins_ok;

	// clearing sweep after reset, one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == IDX_LAST) clr_q <= 1'b0;
			else clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end

	// slot memory; a same-cycle insert to the read slot is forwarded
	always_ff @(posedge clk) begin
		if (clr_q) mem[clr_idx_q] <= '0;
		else if (wr_en) mem[idx_s5] <= handle_s5;
		if (take && ctl.valid) begin
			rd_s5 <= (wr_en && (idx_s5 == idx)) ? handle_s5 : mem[idx];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take) v_s5 <= ctl.valid;
			if (en_out) out_v_q <= v_s5;
		end
	end

	// read stage and result payload
	always_ff @(posedge clk) begin
		if (take && ctl.valid) begin
			lookup_s5 <= ctl.lookup;
			idx_s5    <= idx;
			handle_s5 <= handle;
		end
		if (en_out && v_s5) begin
			succ_q  <= lookup_s5 ? !slot_empty : ins_ok;
			found_q <= lookup_s5 ? rd_s5 : '0;
			idx_q   <= idx_s5;
		end
	end

	assign results.valid        = out_v_q;
	assign results.success      = succ_q;
	assign results.found_handle = found_q;
	assign results.slot_index   = idx_q;

endmodule

// File: design/hashed_symbol_slot_table.sv
// Channel   Role  Request fields
// chars     sink  operation, char_code, is_last, symbol_handle
// results   src   success, found_handle, slot_index
//
// One character is taken per cycle unless back-pressure or the clearing sweep holds
// chars.ready low; a name's result passes four hash stages, the slot read stage and
// the result register. The hash register closes the per-character hash loop.
// After reset a sweep clears every slot of the memory while chars.ready is held low.
// A stalled result holds in its register while upstream stages keep filling.
module hashed_symbol_slot_table #(
	parameter int TABLE_SIZE   = hsst_pkg::TABLE_SIZE_DEF,
	parameter int MAX_NAME_LEN = hsst_pkg::MAX_NAME_LEN_DEF,
	parameter int HANDLE_WIDTH = hsst_pkg::HANDLE_WIDTH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	hsst_chars_if.sink     chars,
	hsst_results_if.source results
);

	localparam int IDX_W = $clog2(TABLE_SIZE);

	hsst_pkg::name_ctl_t     ctl;
	hsst_pkg::table_stat_t   stat;
	logic [IDX_W-1:0]        idx;
	logic [HANDLE_WIDTH-1:0] handle;

	// name hash
	hsst_hash #(
		.TABLE_SIZE   (TABLE_SIZE),
		.MAX_NAME_LEN (MAX_NAME_LEN),
		.HANDLE_WIDTH (HANDLE_WIDTH),
		.IDX_W        (IDX_W)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.stat   (stat),
		.ctl    (ctl),
		.idx    (idx),
		.handle (handle)
	);

	// slot table
	hsst_table #(
		.TABLE_SIZE   (TABLE_SIZE),
		.HANDLE_WIDTH (HANDLE_WIDTH),
		.IDX_W        (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.idx     (idx),
		.handle  (handle),
		.stat    (stat),
		.results (results)
	);

endmodule

// File: design/hsst_checker.sv
// Port-level checks on the result channel.
module hsst_checker #(
	parameter int TABLE_SIZE   = hsst_pkg::TABLE_SIZE_DEF,
	parameter int HANDLE_WIDTH = hsst_pkg::HANDLE_WIDTH_DEF,
	parameter int IDX_W        = $clog2(TABLE_SIZE)
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    success,
	input logic [HANDLE_WIDTH-1:0] found_handle,
	input logic [IDX_W-1:0]        slot_index
);

	// a waiting result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// slot index is a real slot
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot_index < IDX_W'(TABLE_SIZE)))
		else $error("slot index out of table");

	// a returned handle means the slot was occupied
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (found_handle != '0) |-> success)
		else $error("handle returned without success");

	// a failed request returns no handle
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> (found_handle == '0))
		else $error("handle returned on failure");

endmodule

bind hashed_symbol_slot_table hsst_checker #(
	.TABLE_SIZE   (TABLE_SIZE),
	.HANDLE_WIDTH (HANDLE_WIDTH)
) u_hsst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.success      (results.success),
	.found_handle (results.found_handle),
	.slot_index   (results.slot_index)
);

// File: bench/tb_hashed_symbol_slot_table.sv
`timescale 1ns / 1ps

module tb_hashed_symbol_slot_table;

	localparam int SLOT_COUNT  = hsst_pkg::TABLE_SIZE_DEF;
	localparam int POS_LIMIT   = hsst_pkg::MAX_NAME_LEN_DEF;
	localparam int HW          = hsst_pkg::HANDLE_WIDTH_DEF;
	localparam int CW          = hsst_pkg::CHAR_W;
	localparam int IDX_W       = $clog2(SLOT_COUNT);
	localparam int ITEMS       = 500;
	localparam int LATENCY     = 6;
	localparam int STALL_LIMIT = 4000;
	localparam int SAVED_MAX   = 16;
	localparam int SHORT_MAX   = 6;

	// one finished name as the block reports it
	typedef struct packed {
		logic           success;
		logic [HW-1:0]  found;
		logic [IDX_W-1:0] slot;
	} slot_result_t;

	// running hash, position and slot contents, plus the queue of due results
	class slot_table_scoreboard;
		logic [IDX_W-1:0] name_hash;
		int unsigned      name_pos;
		logic [HW-1:0]    slots [SLOT_COUNT];
		slot_result_t     due_results [$];
		int unsigned      errors;
		int unsigned      names_checked;
		int unsigned      stored_inserts;
		int unsigned      lookup_hits;

		function new();
			name_hash = '0;
			name_pos = 0;
			foreach (slots[i]) slots[i] = '0;
			errors = 0;
			names_checked = 0;
			stored_inserts = 0;
			lookup_hits = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// update the hash for one accepted character; a last one yields a result
		function void note_char(hsst_pkg::op_t op, logic [CW-1:0] code, logic last,
			logic [HW-1:0] handle);
			int unsigned  hv;
			int unsigned  cv;
			int unsigned  acc;
			int unsigned  slot;
			slot_result_t r;
			hv = name_hash;
			cv = code;
			acc = (hv << hsst_pkg::HASH_SHIFT) + cv * (name_pos + hsst_pkg::POS_OFFSET);
			slot = acc % SLOT_COUNT;
			if (!last) begin
				name_hash = slot[IDX_W-1:0];
				if (name_pos < POS_LIMIT)
					name_pos++;
				return;
			end
			r.slot = slot[IDX_W-1:0];
			r.found = '0;
			r.success = 1'b0;
			if (op == hsst_pkg::OP_INSERT) begin
				if (slots[slot] == '0 && handle != '0) begin
					slots[slot] = handle;
					r.success = 1'b1;
					stored_inserts++;
				end
			end else begin
				r.found = slots[slot];
				r.success = (slots[slot] != '0);
				if (r.success)
					lookup_hits++;
			end
			due_results.push_back(r);
			name_hash = '0;
			name_pos = 0;
		endfunction

		// compare one accepted result with the oldest due one
		function void check_result(logic success, logic [HW-1:0] found,
			logic [IDX_W-1:0] slot);
			slot_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result success=%0b handle=%h slot=%0d",
						$time, success, found, slot);
				return;
			end
			want = due_results.pop_front();
			names_checked++;
			if (want.success !== success || want.found !== found || want.slot !== slot) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: mismatch: expected success=%0b handle=%h slot=%0d,",
						" got success=%0b handle=%h slot=%0d"},
						$time, want.success, want.found, want.slot, success, found, slot);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hsst_chars_if #(.HANDLE_WIDTH(HW)) chars_bus ();
	hsst_results_if #(.HANDLE_WIDTH(HW), .IDX_W(IDX_W)) res_bus ();

	hashed_symbol_slot_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_bus),
		.results(res_bus)
	);

	slot_table_scoreboard slots_sb = new();

	int unsigned       chars_sent;
	int unsigned       stall_cycles;
	logic              quiet_src;
	logic              quiet_dst;
	logic [CW-1:0]     name_buf [0:399];
	logic [CW-1:0]     saved_chars [SAVED_MAX][SHORT_MAX];
	int                saved_len [SAVED_MAX];
	int                saved_count;
	int                saved_next;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on cycles with no request moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars_bus.valid && chars_bus.ready) || (res_bus.valid && res_bus.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("[hashed_symbol_slot_table] ERROR");
				$finish;
			end
		end
	end

	// present one character request and hold it until taken
	task automatic send_char(input hsst_pkg::op_t op, input logic [CW-1:0] code,
		input logic last, input logic [HW-1:0] handle);
		int gap;
		gap = quiet_src ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			chars_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_bus.valid <= 1'b1;
		chars_bus.operation <= op;
		chars_bus.char_code <= code;
		chars_bus.is_last <= last;
		chars_bus.symbol_handle <= handle;
		do @(posedge clk); while (!chars_bus.ready);
		slots_sb.note_char(op, code, last, handle);
		chars_sent++;
	endtask

	// name_buf[0..len-1]; op and handle on inner characters are noise
	task automatic send_name(input hsst_pkg::op_t op, input int len,
		input logic [HW-1:0] handle);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send_char(op, name_buf[i], 1'b1, handle);
			else
				send_char(hsst_pkg::op_t'($urandom_range(0, 1)), name_buf[i], 1'b0,
					HW'($urandom_range(0, 65535)));
		end
	endtask

	// hold off the sender until every due result is back
	task automatic drain_results();
		chars_bus.valid <= 1'b0;
		do @(posedge clk); while (slots_sb.pending() != 0);
	endtask

	// result side: random stalls, then take and check
	task automatic take_results();
		int gap;
		forever begin
			gap = quiet_dst ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				res_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
			slots_sb.check_result(res_bus.success, res_bus.found_handle, res_bus.slot_index);
		end
	endtask

	initial begin
		res_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		take_results();
	end

	initial begin
		int            pick;
		int            len;
		int            idx;
		hsst_pkg::op_t op;
		logic [HW-1:0] handle;

		clk = 1'b0;
		arst_n = 1'b0;
		chars_bus.valid = 1'b0;
		chars_bus.operation = hsst_pkg::OP_INSERT;
		chars_bus.char_code = '0;
		chars_bus.is_last = 1'b0;
		chars_bus.symbol_handle = '0;
		chars_sent = 0;
		stall_cycles = 0;
		quiet_src = 1'b0;
		quiet_dst = 1'b0;
		saved_count = 0;
		saved_next = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty lookup, null handle, store, taken slot, hit
		name_buf[0] = 7'h41;
		send_name(hsst_pkg::OP_LOOKUP, 1, 16'h0000);
		send_name(hsst_pkg::OP_INSERT, 1, 16'h0000);
		send_name(hsst_pkg::OP_INSERT, 1, 16'hFFFF);
		send_name(hsst_pkg::OP_INSERT, 1, 16'h1234);
		send_name(hsst_pkg::OP_LOOKUP, 1, 16'h0000);
		// character code zero still shifts; all-zero names land on slot 0
		name_buf[0] = 7'h00;
		send_name(hsst_pkg::OP_INSERT, 1, 16'h0001);
		name_buf[1] = 7'h00;
		name_buf[2] = 7'h00;
		send_name(hsst_pkg::OP_LOOKUP, 3, 16'hFFFF);
		// top code, with noise on the operation of inner characters
		for (int i = 0; i < 4; i++) name_buf[i] = 7'h7F;
		send_name(hsst_pkg::OP_INSERT, 4, 16'h8000);
		send_name(hsst_pkg::OP_LOOKUP, 4, 16'h7FFF);
		name_buf[0] = 7'h7A;
		send_name(hsst_pkg::OP_INSERT, 1, 16'h5555);
		send_name(hsst_pkg::OP_LOOKUP, 1, 16'hAAAA);
		drain_results();

		// one name past the position limit
		len = $urandom_range(POS_LIMIT + 1, POS_LIMIT + 40);
		for (int i = 0; i < len; i++) name_buf[i] = CW'($urandom_range(0, 127));
		send_name(hsst_pkg::op_t'($urandom_range(0, 1)), len, HW'($urandom_range(1, 65535)));

		// random names: fresh ones, and replays of stored names for hits and taken slots
		while (chars_sent < ITEMS) begin
			if ($urandom_range(0, 11) == 0) quiet_src = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 11) == 0) quiet_dst = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			handle = ($urandom_range(0, 9) == 0) ? '0 : HW'($urandom_range(0, 65535));
			if (pick < 4) begin
				drain_results();
			end else if (pick < 40 && saved_count > 0) begin
				idx = $urandom_range(0, saved_count - 1);
				len = saved_len[idx];
				for (int i = 0; i < len; i++) name_buf[i] = saved_chars[idx][i];
				op = ($urandom_range(0, 3) == 0) ? hsst_pkg::OP_INSERT : hsst_pkg::OP_LOOKUP;
				send_name(op, len, handle);
			end else begin
				len = $urandom_range(1, SHORT_MAX);
				for (int i = 0; i < len; i++) name_buf[i] = CW'($urandom_range(0, 127));
				op = hsst_pkg::op_t'($urandom_range(0, 1));
				if (op == hsst_pkg::OP_INSERT) begin
					for (int i = 0; i < len; i++) saved_chars[saved_next][i] = name_buf[i];
					saved_len[saved_next] = len;
					saved_next = (saved_next + 1) % SAVED_MAX;
					if (saved_count < SAVED_MAX) saved_count++;
				end
				send_name(op, len, handle);
			end
		end

		// wind down: all results back, then a further wait to catch strays
		drain_results();
		repeat (LATENCY * 4) @(posedge clk);

		$display("Sent %0d characters; %0d names checked, %0d inserts stored,",
			chars_sent, slots_sb.names_checked, slots_sb.stored_inserts);
		$display("%0d lookup hits, %0d mismatches", slots_sb.lookup_hits, slots_sb.errors);
		if (slots_sb.errors == 0 && slots_sb.pending() == 0)
			$display("[hashed_symbol_slot_table] OK");
		else
			$display("[hashed_symbol_slot_table] ERROR");
		$finish;
	end

endmodule

// File: sim.f
design/hsst_pkg.sv
design/hsst_if.sv
design/hsst_hash.sv
design/hsst_table.sv
design/hashed_symbol_slot_table.sv
design/hsst_checker.sv
bench/tb_hashed_symbol_slot_table.sv
